// ----- hw/rtl/abd_pkg.sv -----
package abd_pkg;

   localparam int PRECISION = 10;
   localparam int CONTEXTS  = 64;
   localparam int FIFO_BITS = 256;

   localparam int VW   = PRECISION + 1;
   localparam int CW   = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
   localparam int FAW  = $clog2(FIFO_BITS);
   localparam int FFW  = $clog2(FIFO_BITS + 1);
   localparam int CNTW = 16;
   localparam int DVW  = (CNTW + PRECISION + 2 > 2 * CNTW) ? CNTW + PRECISION + 2 : 2 * CNTW;
   localparam int DSW  = CNTW + 1;
   localparam int DCW  = $clog2(DVW);
   localparam int GW   = $clog2(2 * PRECISION + 2);
   localparam int QD   = 4;
   localparam int QAW  = $clog2(QD);
   localparam int REQ_CTXW = 6;

   localparam logic [VW-1:0]   TOP  = VW'(1) << PRECISION;
   localparam logic [VW-1:0]   HALF = TOP >> 1;
   localparam logic [VW-1:0]   QTR1 = TOP >> 2;
   localparam logic [VW-1:0]   QTR3 = (TOP >> 2) * 3;
   localparam logic [CNTW-1:0] CNT_MAX = '1;
   localparam logic [CNTW-1:0] TOTAL_RESET = 16'd16;

   localparam logic CSR_RESET_TOTAL  = 1'b0;
   localparam logic CSR_RESIZE_TOTAL = 1'b1;

   typedef enum logic [2:0] {
      CMD_PUSH    = 3'd0,
      CMD_START   = 3'd1,
      CMD_DECODE  = 3'd2,
      CMD_RESET   = 3'd3,
      CMD_RESCALE = 3'd4
   } cmd_type;

   typedef struct packed {
      cmd_type       cmd;
      logic [7:0]    data_byte;
      logic [CW-1:0] ctx;
   } item_type;

   typedef logic [CW-1:0] ctx_map_type [2**REQ_CTXW];

   function automatic ctx_map_type mk_ctx_map();
      ctx_map_type m;
      for (int k = 0; k < 2**REQ_CTXW; k++) begin
         m[k] = CW'(k % CONTEXTS);
      end
      return m;
   endfunction

   localparam ctx_map_type CTX_MAP = mk_ctx_map();

endpackage

// ----- hw/rtl/abd_ifs.sv -----
interface abd_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] cmd;
   logic [7:0] data_byte;
   logic [5:0] context_req;
   modport source (output valid, cmd, data_byte, context_req, input ready);
   modport sink (input valid, cmd, data_byte, context_req, output ready);
endinterface

interface abd_rsp_if;
   logic valid;
   logic ready;
   logic symbol;
   logic underrun;
   modport source (output valid, symbol, underrun, input ready);
   modport sink (input valid, symbol, underrun, output ready);
endinterface

// ----- hw/rtl/adaptive_binary_arith_decoder_top.sv -----
// Adaptive binary arithmetic decoder. Transactions enter a four-deep command queue and are
// executed one at a time by the back end, which holds a 256-bit input FIFO and a count
// memory of 64 contexts. After a transaction leaves the queue: push writes up to eight bits
// into the FIFO; start shifts in ten code bits; decode reads the counts, divides, splits,
// renormalizes and may wait for the output register, its time mostly set by the 32-step shared
// restoring divider; count reset writes one context per cycle; rescale reads, multiplies,
// divides and writes each context in turn, again with the divider. A result waits in an
// output register while the next transactions are queued. Configuration writes are taken at
// any time but must only be issued while the block is idle.
module adaptive_binary_arith_decoder_top (
   input  logic        clock,
   input  logic        reset,
   abd_req_if.sink     req_if,
   abd_rsp_if.source   rsp_if,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   logic              q_valid;
   logic              q_pop;
   abd_pkg::item_type q_item;

   abd_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop)
   );

   abd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule

// ----- hw/rtl/abd_front.sv -----
module abd_front (
   input  logic             clock,
   input  logic             reset,
   abd_req_if.sink          req_if,
   output logic             q_valid,
   output abd_pkg::item_type q_item,
   input  logic             q_pop
);

   abd_pkg::item_type       q_mem [abd_pkg::QD];
   logic [abd_pkg::QAW-1:0] wr_ptr_ff;
   logic [abd_pkg::QAW-1:0] rd_ptr_ff;
   logic [abd_pkg::QAW:0]   count_ff;
   logic                    known;
   logic                    push;
   abd_pkg::item_type       new_item;

   always_comb begin
      unique case (req_if.cmd)
         abd_pkg::CMD_PUSH, abd_pkg::CMD_START, abd_pkg::CMD_DECODE,
         abd_pkg::CMD_RESET, abd_pkg::CMD_RESCALE: known = 1'b1;
         default: known = 1'b0;
      endcase
   end

   assign req_if.ready = (count_ff != (abd_pkg::QAW+1)'(abd_pkg::QD));
   assign push = req_if.valid && req_if.ready && known;
   assign q_valid = (count_ff != '0);
   assign q_item = q_mem[rd_ptr_ff];

   always_comb begin
      new_item.cmd       = abd_pkg::cmd_type'(req_if.cmd);
      new_item.data_byte = req_if.data_byte;
      new_item.ctx       = abd_pkg::CTX_MAP[req_if.context_req];
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= new_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (q_pop && q_valid) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + (abd_pkg::QAW+1)'(push) - (abd_pkg::QAW+1)'(q_pop && q_valid);
      end
   end

endmodule

// ----- hw/rtl/abd_back.sv -----
module abd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  abd_pkg::item_type q_item,
   output logic              q_pop,
   abd_rsp_if.source         rsp_if,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [15:0]       csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE, S_PUSH, S_START, S_CLR, S_RS_RD, S_RS_MUL, S_RS_WR,
      S_D_RD, S_D_LD, S_DIV, S_D_MUL, S_D_SPL, S_RENORM, S_D_UPD, S_D_OUT
   } state_type;

   localparam int CNT2 = 2 * abd_pkg::CNTW;
   localparam int VW   = abd_pkg::VW;
   localparam int DVW  = abd_pkg::DVW;
   localparam int DSW  = abd_pkg::DSW;

   state_type state_ff;
   abd_pkg::item_type item_ff;

   logic [VW-1:0] lo_ff, hi_ff, wid_ff, cv_ff;
   logic          sym_ff, und_ff;
   logic [abd_pkg::GW-1:0] gd_ff;
   logic          settle_ff;
   logic [2:0]    bit_idx_ff;

   logic          fifo_mem [abd_pkg::FIFO_BITS];
   logic [abd_pkg::FAW-1:0] head_ff;
   logic [abd_pkg::FFW-1:0] fill_ff;
   logic          rd_bit_ff;
   logic          fifo_we;
   logic [abd_pkg::FAW-1:0] fifo_waddr;
   logic [abd_pkg::FFW:0]   fifo_sum;
   logic [abd_pkg::FAW-1:0] head_next;

   logic [CNT2-1:0] cnt_mem [abd_pkg::CONTEXTS];
   logic [abd_pkg::CW-1:0] cnt_addr_ff;
   logic [CNT2-1:0] cnt_q_ff;
   logic          cnt_we;
   logic [CNT2-1:0] cnt_wdata;

   logic [15:0]   reset_total_ff, resize_total_ff;

   logic [DVW-1:0] dvd_ff, quo_ff;
   logic [DSW-1:0] dsor_ff, rem_ff;
   logic [abd_pkg::DCW-1:0] dcnt_ff;
   logic           is_dec_ff;
   logic [DSW:0]   rem2;
   logic           qbit;

   logic [2*VW-1:0] prod_ff;

   logic [15:0]   zero_q, total_q;
   logic [VW-1:0] w_clip, p_val, split_raw, split, value;
   logic          rn_go;
   logic [VW-1:0] sub, cv_sub, lo_rn, hi_rn, cv_rn;
   logic          bit_in;
   logic [15:0]   z_sat, z_fin, zero_up, total_up;

   logic rsp_valid_ff, rsp_und_ff, rsp_sym_ff;

   assign zero_q  = cnt_q_ff[CNT2-1:abd_pkg::CNTW];
   assign total_q = cnt_q_ff[abd_pkg::CNTW-1:0];

   always_comb begin
      rem2 = {rem_ff, dvd_ff[DVW-1]};
      qbit = (rem2 >= {1'b0, dsor_ff});

      w_clip = (wid_ff > abd_pkg::TOP) ? abd_pkg::TOP : wid_ff;
      if (total_q == '0) begin
         p_val = '0;
      end else if (quo_ff > DVW'(abd_pkg::TOP)) begin
         p_val = abd_pkg::TOP;
      end else begin
         p_val = quo_ff[VW-1:0];
      end
      split_raw = prod_ff[abd_pkg::PRECISION +: VW];
      if (split_raw == '0) begin
         split = VW'(1);
      end else if (split_raw >= w_clip) begin
         split = w_clip - 1'b1;
      end else begin
         split = split_raw;
      end
      value = (cv_ff >= lo_ff) ? cv_ff - lo_ff : '0;

      rn_go = 1'b1;
      sub   = '0;
      if (hi_ff <= abd_pkg::HALF) begin
         sub = '0;
      end else if (lo_ff >= abd_pkg::HALF) begin
         sub = abd_pkg::HALF;
      end else if (lo_ff >= abd_pkg::QTR1 && hi_ff <= abd_pkg::QTR3) begin
         sub = abd_pkg::QTR1;
      end else begin
         rn_go = 1'b0;
      end
      bit_in = (fill_ff != '0) ? rd_bit_ff : 1'b0;
      cv_sub = (cv_ff >= sub) ? cv_ff - sub : '0;
      lo_rn  = (lo_ff - sub) << 1;
      hi_rn  = (hi_ff - sub) << 1;
      cv_rn  = {cv_sub[VW-2:0], bit_in};

      if (total_q == '0) begin
         z_sat = '0;
      end else if (quo_ff > DVW'(abd_pkg::CNT_MAX)) begin
         z_sat = abd_pkg::CNT_MAX;
      end else begin
         z_sat = quo_ff[15:0];
      end
      z_fin = (z_sat == '0) ? 16'd1 : z_sat;
      if (z_fin == resize_total_ff) begin
         z_fin = resize_total_ff - 1'b1;
      end

      zero_up  = (!sym_ff && zero_q < abd_pkg::CNT_MAX) ? zero_q + 1'b1 : zero_q;
      total_up = (total_q < abd_pkg::CNT_MAX) ? total_q + 1'b1 : total_q;
   end

   always_comb begin
      fifo_sum   = (abd_pkg::FFW+1)'(head_ff) + (abd_pkg::FFW+1)'(fill_ff);
      fifo_waddr = (fifo_sum >= (abd_pkg::FFW+1)'(abd_pkg::FIFO_BITS))
                   ? abd_pkg::FAW'(fifo_sum - (abd_pkg::FFW+1)'(abd_pkg::FIFO_BITS))
                   : abd_pkg::FAW'(fifo_sum);
      fifo_we    = (state_ff == S_PUSH) && (fill_ff < abd_pkg::FFW'(abd_pkg::FIFO_BITS));
      head_next  = (head_ff == abd_pkg::FAW'(abd_pkg::FIFO_BITS - 1)) ? '0 : head_ff + 1'b1;

      cnt_we    = 1'b0;
      cnt_wdata = {zero_up, total_up};
      unique case (state_ff)
         S_CLR: begin
            cnt_we    = 1'b1;
            cnt_wdata = {1'b0, reset_total_ff[15:1], reset_total_ff};
         end
         S_RS_WR: begin
            cnt_we    = 1'b1;
            cnt_wdata = {z_fin, resize_total_ff};
         end
         S_D_UPD: cnt_we = 1'b1;
         default: cnt_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (fifo_we) begin
         fifo_mem[fifo_waddr] <= item_ff.data_byte[bit_idx_ff];
      end
      rd_bit_ff <= fifo_mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_addr_ff] <= cnt_wdata;
      end
      cnt_q_ff <= cnt_mem[cnt_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reset_total_ff  <= abd_pkg::TOTAL_RESET;
         resize_total_ff <= abd_pkg::TOTAL_RESET;
      end else if (csr_we) begin
         if (csr_index == abd_pkg::CSR_RESET_TOTAL) begin
            reset_total_ff <= csr_wdata;
         end else begin
            resize_total_ff <= csr_wdata;
         end
      end
   end

   assign q_pop           = (state_ff == S_IDLE) && q_valid;
   assign rsp_if.symbol   = rsp_sym_ff;
   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.underrun = rsp_und_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lo_ff        <= '0;
         hi_ff        <= abd_pkg::TOP;
         wid_ff       <= abd_pkg::TOP;
         cv_ff        <= '0;
         head_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         settle_ff    <= 1'b0;
      end else begin
         if (state_ff == S_D_OUT && (!rsp_valid_ff || rsp_if.ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  item_ff     <= q_item;
                  bit_idx_ff  <= '0;
                  gd_ff       <= '0;
                  settle_ff   <= 1'b0;
                  cnt_addr_ff <= '0;
                  unique case (q_item.cmd)
                     abd_pkg::CMD_PUSH: state_ff <= S_PUSH;
                     abd_pkg::CMD_START: begin
                        cv_ff    <= '0;
                        lo_ff    <= '0;
                        hi_ff    <= abd_pkg::TOP;
                        wid_ff   <= abd_pkg::TOP;
                        state_ff <= S_START;
                     end
                     abd_pkg::CMD_DECODE: begin
                        cnt_addr_ff <= q_item.ctx;
                        state_ff    <= S_D_RD;
                     end
                     abd_pkg::CMD_RESET: state_ff <= S_CLR;
                     abd_pkg::CMD_RESCALE: state_ff <= S_RS_RD;
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            S_PUSH: begin
               if (fifo_we) begin
                  fill_ff <= fill_ff + 1'b1;
               end
               bit_idx_ff <= bit_idx_ff + 1'b1;
               if (bit_idx_ff == 3'd7) begin
                  state_ff <= S_IDLE;
               end
            end
            S_START: begin
               if (settle_ff) begin
                  settle_ff <= 1'b0;
               end else if (gd_ff == abd_pkg::GW'(abd_pkg::PRECISION)) begin
                  state_ff <= S_IDLE;
               end else begin
                  cv_ff <= {cv_ff[VW-2:0], bit_in};
                  if (fill_ff != '0) begin
                     head_ff <= head_next;
                     fill_ff <= fill_ff - 1'b1;
                  end
                  settle_ff <= 1'b1;
                  gd_ff     <= gd_ff + 1'b1;
               end
            end
            S_CLR: begin
               cnt_addr_ff <= cnt_addr_ff + 1'b1;
               if (cnt_addr_ff == abd_pkg::CW'(abd_pkg::CONTEXTS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_RS_RD: state_ff <= S_RS_MUL;
            S_RS_MUL: begin
               dvd_ff    <= DVW'(zero_q) * DVW'(resize_total_ff);
               dsor_ff   <= {1'b0, total_q};
               rem_ff    <= '0;
               dcnt_ff   <= '0;
               is_dec_ff <= 1'b0;
               state_ff  <= S_DIV;
            end
            S_RS_WR: begin
               cnt_addr_ff <= cnt_addr_ff + 1'b1;
               if (cnt_addr_ff == abd_pkg::CW'(abd_pkg::CONTEXTS - 1)) begin
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_RS_RD;
               end
            end
            S_D_RD: state_ff <= S_D_LD;
            S_D_LD: begin
               dvd_ff    <= (DVW'(zero_q) << (abd_pkg::PRECISION + 1)) + DVW'(total_q);
               dsor_ff   <= {total_q, 1'b0};
               rem_ff    <= '0;
               dcnt_ff   <= '0;
               is_dec_ff <= 1'b1;
               state_ff  <= S_DIV;
            end
            S_DIV: begin
               rem_ff  <= qbit ? DSW'(rem2 - {1'b0, dsor_ff}) : DSW'(rem2);
               quo_ff  <= {quo_ff[DVW-2:0], qbit};
               dvd_ff  <= dvd_ff << 1;
               dcnt_ff <= dcnt_ff + 1'b1;
               if (dcnt_ff == abd_pkg::DCW'(DVW - 1)) begin
                  state_ff <= is_dec_ff ? S_D_MUL : S_RS_WR;
               end
            end
            S_D_MUL: begin
               prod_ff  <= w_clip * p_val;
               state_ff <= S_D_SPL;
            end
            S_D_SPL: begin
               if (value < split) begin
                  hi_ff  <= lo_ff + split;
                  sym_ff <= 1'b0;
               end else begin
                  lo_ff  <= lo_ff + split;
                  sym_ff <= 1'b1;
               end
               und_ff    <= 1'b0;
               gd_ff     <= '0;
               settle_ff <= 1'b0;
               state_ff  <= S_RENORM;
            end
            S_RENORM: begin
               if (settle_ff) begin
                  settle_ff <= 1'b0;
               end else if (!rn_go || gd_ff > abd_pkg::GW'(2 * abd_pkg::PRECISION)) begin
                  state_ff <= S_D_UPD;
               end else begin
                  lo_ff <= lo_rn;
                  hi_ff <= hi_rn;
                  cv_ff <= cv_rn;
                  if (fill_ff != '0) begin
                     head_ff <= head_next;
                     fill_ff <= fill_ff - 1'b1;
                  end else begin
                     und_ff <= 1'b1;
                  end
                  settle_ff <= 1'b1;
                  gd_ff     <= gd_ff + 1'b1;
               end
            end
            S_D_UPD: begin
               wid_ff   <= (hi_ff >= lo_ff) ? hi_ff - lo_ff : '0;
               state_ff <= S_D_OUT;
            end
            S_D_OUT: begin
               if (!rsp_valid_ff || rsp_if.ready) begin
                  rsp_sym_ff <= sym_ff;
                  rsp_und_ff <= und_ff;
                  state_ff   <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ----- hw/rtl/abd_checker.sv -----
module abd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [2:0] req_cmd,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_symbol,
   input logic       rsp_underrun
);

   logic [7:0] pend_ff;
   logic       dec_in, dec_out;

   assign dec_in  = req_valid && req_ready && (req_cmd == abd_pkg::CMD_DECODE);
   assign dec_out = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_ff + 8'(dec_in) - 8'(dec_out);
      end
   end

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_symbol) && $stable(rsp_underrun))
      else $error("stalled result changed");

   a_rsp_owed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != '0)
      else $error("result without an outstanding decode transaction");

endmodule

bind adaptive_binary_arith_decoder_top abd_checker u_abd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_if.valid),
   .req_ready    (req_if.ready),
   .req_cmd      (req_if.cmd),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .rsp_symbol   (rsp_if.symbol),
   .rsp_underrun (rsp_if.underrun)
);

// ----- tb/tb_top.sv -----
module tb_top;

   localparam int unsigned CYCLE_LIMIT = 1500000;
   localparam int unsigned DRAIN_CYCLES = 3000;
   localparam longint unsigned TOPV = 64'd1 << abd_pkg::PRECISION;
   localparam longint unsigned HALFV = TOPV >> 1;
   localparam longint unsigned Q1V = TOPV >> 2;
   localparam longint unsigned Q3V = Q1V * 3;
   localparam int unsigned SAT = 65535;

   typedef struct {
      logic [2:0] cmd;
      logic [7:0] data_byte;
      logic [5:0] ctx;
   } cmd_txn_type;

   typedef struct {
      logic symbol;
      logic underrun;
   } sym_txn_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic        csr_index;
   logic [15:0] csr_wdata;

   abd_req_if req_bus ();
   abd_rsp_if rsp_bus ();

   adaptive_binary_arith_decoder_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   cmd_txn_type pending_cmds[$];
   sym_txn_type expected_syms[$];
   int unsigned errors = 0;
   int unsigned cycles = 0;
   int unsigned n_decodes = 0;
   int unsigned n_underruns = 0;
   int unsigned n_rescales = 0;

   // predictor state
   longint unsigned lo_q, hi_q, width_q, code_q;
   int unsigned zero_cnt[abd_pkg::CONTEXTS];
   int unsigned total_cnt[abd_pkg::CONTEXTS];
   bit bit_q[$];
   int unsigned cfg_reset_total = 16;
   int unsigned cfg_resize_total = 16;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic exp_v, input logic got_v);
      errors++;
      $display("MISMATCH %s: expected %0b got %0b (cycle %0d)", what, exp_v, got_v, cycles);
   endtask

   function automatic bit pull_bit(inout bit b);
      if (bit_q.size() == 0) begin
         b = 1'b0;
         return 1'b0;
      end
      b = bit_q.pop_front();
      return 1'b1;
   endfunction

   task automatic decode_symbol(input int unsigned c);
      longint unsigned zeros, total, p, split, w, value, sub;
      longint unsigned lo, hi, cv;
      bit b;
      logic sym, under;
      sym_txn_type r;
      zeros = zero_cnt[c];
      total = total_cnt[c];
      lo = lo_q;
      hi = hi_q;
      cv = code_q;
      w = width_q;
      sym = 1'b0;
      under = 1'b0;
      p = 0;
      if (total != 0) p = (2 * zeros * TOPV + total) / (2 * total);
      if (p > TOPV) p = TOPV;
      if (w > TOPV) w = TOPV;
      split = (w * p) >> abd_pkg::PRECISION;
      if (split == 0) split = 1;
      else if (split >= w) split = w - 1;
      value = (cv >= lo) ? cv - lo : 0;
      if (value < split) begin
         hi = lo + split;
      end else begin
         sym = 1'b1;
         lo = lo + split;
      end
      for (int g = 0; g <= 2 * abd_pkg::PRECISION; g++) begin
         if (hi <= HALFV) sub = 0;
         else if (lo >= HALFV) sub = HALFV;
         else if (lo >= Q1V && hi <= Q3V) sub = Q1V;
         else break;
         lo = (lo - sub) << 1;
         hi = (hi - sub) << 1;
         cv = ((cv >= sub) ? cv - sub : 0) << 1;
         if (!pull_bit(b)) under = 1'b1;
         cv += b;
         lo &= (TOPV << 1) - 1;
         hi &= (TOPV << 1) - 1;
         cv &= (TOPV << 1) - 1;
      end
      lo_q = lo;
      hi_q = hi;
      width_q = (hi >= lo) ? hi - lo : 0;
      code_q = cv;
      if (!sym && zero_cnt[c] < SAT) zero_cnt[c]++;
      if (total_cnt[c] < SAT) total_cnt[c]++;
      r.symbol = sym;
      r.underrun = under;
      expected_syms.push_back(r);
      n_decodes++;
      if (under) n_underruns++;
   endtask

   task automatic predict_cmd(input cmd_txn_type t);
      longint unsigned z, cv;
      bit b;
      case (t.cmd)
         abd_pkg::CMD_PUSH: begin
            for (int j = 0; j < 8; j++) begin
               if (bit_q.size() < abd_pkg::FIFO_BITS) bit_q.push_back(t.data_byte[j]);
            end
         end
         abd_pkg::CMD_START: begin
            cv = 0;
            for (int i = abd_pkg::PRECISION - 1; i >= 0; i--) begin
               if (!pull_bit(b)) break;
               cv |= longint'(b) << i;
            end
            code_q = cv;
            lo_q = 0;
            hi_q = TOPV;
            width_q = TOPV;
         end
         abd_pkg::CMD_DECODE: decode_symbol(t.ctx % abd_pkg::CONTEXTS);
         abd_pkg::CMD_RESET: begin
            for (int i = 0; i < abd_pkg::CONTEXTS; i++) begin
               zero_cnt[i] = cfg_reset_total / 2;
               total_cnt[i] = cfg_reset_total;
            end
         end
         abd_pkg::CMD_RESCALE: begin
            n_rescales++;
            for (int i = 0; i < abd_pkg::CONTEXTS; i++) begin
               z = 0;
               if (total_cnt[i] != 0)
                  z = (longint'(zero_cnt[i]) * cfg_resize_total) / total_cnt[i];
               if (z > SAT) z = SAT;
               if (z == 0) z = 1;
               total_cnt[i] = cfg_resize_total;
               if (z == cfg_resize_total) z = cfg_resize_total - 1;
               zero_cnt[i] = 32'(z);
            end
         end
         default: ;
      endcase
   endtask

   function automatic bit idle_now();
      if (cycles >= 20000 && cycles < 50000) return 1'b0;
      return $urandom_range(0, 99) < 11;
   endfunction

   // driver
   always @(posedge clock) begin
      cmd_txn_type t;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (req_bus.valid) begin
            t.cmd = req_bus.cmd;
            t.data_byte = req_bus.data_byte;
            t.ctx = req_bus.context_req;
            predict_cmd(t);
            void'(pending_cmds.pop_front());
         end
         if (pending_cmds.size() != 0 && !idle_now()) begin
            req_bus.valid <= 1'b1;
            req_bus.cmd <= pending_cmds[0].cmd;
            req_bus.data_byte <= pending_cmds[0].data_byte;
            req_bus.context_req <= pending_cmds[0].ctx;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      sym_txn_type e;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_syms.size() == 0) begin
               report_mismatch("unexpected symbol transaction", 1'b0, rsp_bus.symbol);
            end else begin
               e = expected_syms.pop_front();
               if (rsp_bus.symbol !== e.symbol)
                  report_mismatch("symbol", e.symbol, rsp_bus.symbol);
               if (rsp_bus.underrun !== e.underrun)
                  report_mismatch("underrun", e.underrun, rsp_bus.underrun);
            end
         end
         rsp_bus.ready <= !idle_now();
      end
   end

   task automatic add_cmd(input logic [2:0] c, input logic [7:0] d, input logic [5:0] x);
      cmd_txn_type t;
      t.cmd = c;
      t.data_byte = d;
      t.ctx = x;
      pending_cmds.push_back(t);
   endtask

   task automatic write_csr(input logic idx, input logic [15:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == abd_pkg::CSR_RESET_TOTAL) cfg_reset_total = val;
      else cfg_resize_total = val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_cmds.size() != 0 || req_bus.valid || expected_syms.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic add_directed();
      add_cmd(abd_pkg::CMD_PUSH, 8'h00, 6'd0);
      add_cmd(abd_pkg::CMD_PUSH, 8'hFF, 6'd0);
      add_cmd(abd_pkg::CMD_START, 8'h00, 6'd0);
      add_cmd(abd_pkg::CMD_DECODE, 8'h00, 6'd0);
      add_cmd(abd_pkg::CMD_DECODE, 8'hFF, 6'd63);
      add_cmd(abd_pkg::CMD_DECODE, 8'h00, 6'd63);
      add_cmd(abd_pkg::CMD_PUSH, 8'hA5, 6'd0);
      add_cmd(abd_pkg::CMD_START, 8'h00, 6'd0);
      add_cmd(abd_pkg::CMD_DECODE, 8'h00, 6'd5);
      add_cmd(abd_pkg::CMD_DECODE, 8'h00, 6'd5);
      add_cmd(abd_pkg::CMD_DECODE, 8'h00, 6'd42);
      add_cmd(abd_pkg::CMD_RESCALE, 8'h00, 6'd0);
      add_cmd(abd_pkg::CMD_DECODE, 8'h00, 6'd63);
      add_cmd(3'd5, 8'hFF, 6'd63);
      add_cmd(3'd6, 8'h5A, 6'd21);
      add_cmd(3'd7, 8'h00, 6'd0);
      add_cmd(abd_pkg::CMD_START, 8'h00, 6'd0);
      add_cmd(abd_pkg::CMD_DECODE, 8'h00, 6'd1);
      add_cmd(abd_pkg::CMD_RESET, 8'h00, 6'd0);
   endtask

   task automatic add_random(input int unsigned n);
      int unsigned made, r, k, kp, rescales;
      logic [5:0] base;
      made = 0;
      rescales = 0;
      while (made < n) begin
         r = $urandom_range(0, 99);
         if (r < 80) begin
            kp = (r < 3) ? 34 : $urandom_range(1, 6);
            repeat (kp) add_cmd(abd_pkg::CMD_PUSH, $urandom_range(0, 255), $urandom_range(0, 63));
            add_cmd(abd_pkg::CMD_START, $urandom_range(0, 255), $urandom_range(0, 63));
            base = $urandom_range(0, 63);
            k = $urandom_range(1, 24);
            repeat (k) begin
               if ($urandom_range(0, 9) == 0)
                  add_cmd(abd_pkg::CMD_DECODE, $urandom_range(0, 255), $urandom_range(0, 63));
               else
                  add_cmd(abd_pkg::CMD_DECODE, $urandom_range(0, 255),
                          base + $urandom_range(0, 3));
            end
            made += kp + 1 + k;
         end else if (r < 85 && rescales < 3) begin
            rescales++;
            add_cmd(abd_pkg::CMD_RESCALE, $urandom_range(0, 255), $urandom_range(0, 63));
            made++;
         end else if (r < 90) begin
            add_cmd(abd_pkg::CMD_RESET, $urandom_range(0, 255), $urandom_range(0, 63));
            made++;
         end else if (r < 95) begin
            add_cmd($urandom_range(5, 7), $urandom_range(0, 255), $urandom_range(0, 63));
            made++;
         end else begin
            add_cmd($urandom_range(0, 1), $urandom_range(0, 255), $urandom_range(0, 63));
            made++;
         end
      end
   endtask

   initial begin
      logic [15:0] reset_totals[6];
      logic [15:0] resize_totals[6];
      req_bus.valid = 1'b0;
      req_bus.cmd = abd_pkg::CMD_PUSH;
      req_bus.data_byte = 8'h00;
      req_bus.context_req = 6'd0;
      rsp_bus.ready = 1'b0;
      csr_we = 1'b0;
      csr_index = abd_pkg::CSR_RESET_TOTAL;
      csr_wdata = 16'd0;
      reset = 1'b1;
      lo_q = 0;
      hi_q = TOPV;
      width_q = TOPV;
      code_q = 0;
      for (int i = 0; i < abd_pkg::CONTEXTS; i++) begin
         zero_cnt[i] = 0;
         total_cnt[i] = 0;
      end
      reset_totals = '{16'd16, 16'd2, 16'd65535, 16'd2, 16'd65535, 16'd0};
      resize_totals = '{16'd16, 16'd2, 16'd65535, 16'd65535, 16'd2, 16'd0};
      reset_totals[5] = $urandom_range(2, 65535);
      resize_totals[5] = $urandom_range(2, 65535);
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < 6; ph++) begin
         write_csr(abd_pkg::CSR_RESET_TOTAL, reset_totals[ph]);
         write_csr(abd_pkg::CSR_RESIZE_TOTAL, resize_totals[ph]);
         @(negedge clock);
         add_cmd(abd_pkg::CMD_RESET, 8'h00, 6'd0);
         if (ph == 0) add_directed();
         add_random(310);
         wait_idle();
      end
      $display("Ran six count settings: %0d symbols decoded, %0d with underrun, %0d rescales",
               n_decodes, n_underruns, n_rescales);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches", errors);
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/abd_pkg.sv
hw/rtl/abd_ifs.sv
hw/rtl/abd_front.sv
hw/rtl/abd_back.sv
hw/rtl/adaptive_binary_arith_decoder_top.sv
hw/rtl/abd_checker.sv
tb/tb_top.sv
